// File: rtl/lru_page_replacement_top_assert.svh
// ----------------------------------------------------------------------------
// LRU page replacement assertion macros
// Short forms for the concurrent checks used in the page replacement block.
// ----------------------------------------------------------------------------
`ifndef LRU_PAGE_REPLACEMENT_TOP_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_TOP_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define LRUPR_ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define LRUPR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/lrupr_pkg.sv
// ----------------------------------------------------------------------------
// LRU page replacement package
// Sizes, field widths, shared types and the frame count clamp.
// ----------------------------------------------------------------------------
package lrupr_pkg;

   localparam int FRAME_COUNT  = 8;
   localparam int PAGE_BITS    = 16;

   localparam int FRAME_W      = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
   localparam int COUNT_W      = $clog2(FRAME_COUNT + 1);

   localparam int CFG_W        = 4;
   localparam int CFG_RESET    = 8;

   localparam int REQ_PAGE_W   = 16;
   localparam int REQ_DATA_W   = 16;

   localparam int FRAME_IDX_W  = 3;
   localparam int EVICT_PAGE_W = 16;
   localparam int FAULT_W      = 32;
   localparam int RSP_RAW_W    = FRAME_IDX_W + 1 + EVICT_PAGE_W + FAULT_W;
   localparam int RSP_DATA_W   = ((RSP_RAW_W + 7) / 8) * 8;
   localparam int RSP_USER_W   = 1;

   // One stored entry of the recency chain.
   typedef struct packed {
      logic                 valid;
      logic [PAGE_BITS-1:0] page;
      logic [FRAME_W-1:0]   frame;
   } entry_type;

   typedef struct packed {
      logic load;
      logic flush;
   } cell_ctrl_type;

   // Out of range settings fall back to one frame or to the full table.
   function automatic logic [COUNT_W-1:0] clamp_frames(input logic [CFG_W-1:0] value);
      logic [COUNT_W-1:0] result;
      if (value == '0) begin
         result = COUNT_W'(1);
      end else if (32'(value) > FRAME_COUNT) begin
         result = COUNT_W'(FRAME_COUNT);
      end else begin
         result = COUNT_W'(value);
      end
      return result;
   endfunction

endpackage

// File: rtl/lrupr_cell.sv
// ----------------------------------------------------------------------------
// LRU page replacement chain cell
// Holds one entry of the recency order and compares it against the lookup.
// ----------------------------------------------------------------------------
module lrupr_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  lrupr_pkg::cell_ctrl_type       ctrl,
   input  lrupr_pkg::entry_type           prev_entry,
   input  logic [lrupr_pkg::PAGE_BITS-1:0] lookup_page,
   output lrupr_pkg::entry_type           entry,
   output logic                           match
);
   import lrupr_pkg::*;

   logic                 valid_ff;
   logic                 valid_in;
   logic [PAGE_BITS-1:0] page_ff;
   logic [PAGE_BITS-1:0] page_in;
   logic [FRAME_W-1:0]   frame_ff;
   logic [FRAME_W-1:0]   frame_in;

   always_comb begin
      valid_in = valid_ff;
      page_in  = page_ff;
      frame_in = frame_ff;
      if (ctrl.flush) begin
         valid_in = 1'b0;
      end else if (ctrl.load) begin
         valid_in = prev_entry.valid;
         page_in  = prev_entry.page;
         frame_in = prev_entry.frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff  <= page_in;
      frame_ff <= frame_in;
   end

   assign entry.valid = valid_ff;
   assign entry.page  = page_ff;
   assign entry.frame = frame_ff;
   assign match       = valid_ff && (page_ff == lookup_page);

endmodule

// File: rtl/lru_page_replacement_top.sv
// ----------------------------------------------------------------------------
// LRU page replacement table
// Move-to-front chain of cells that tracks resident pages in recency order.
// ----------------------------------------------------------------------------
// Usage:
//   A page reference enters on the req_ stream; each one yields exactly one
//   result word on the rsp_ stream with the hit/fault flag, the frame that
//   holds the page, any evicted page and the saturating fault count.
//   Cell 0 of the chain holds the most recent page. A lookup compares every
//   cell at once; on a hit the cells ahead of the match shift back by one,
//   on a miss the whole active chain shifts and the last cell drops out as
//   the victim once all frames are filled. Empty frames fill in order.
//   rsp_tvalid is set in the cycle after acceptance. One word is taken per
//   cycle unless a stalled receiver holds the result register.
//   The result register refills in the cycle it is read, so a stalled
//   receiver holds the current word and blocks only new requests.
//   Reset empties the table, clears the fault count and selects all frames.
//   A csr_ write sets the frame count and empties the table, keeping the
//   fault count; the user writes it only while no word is in flight, and the block does not enforce this.
// ----------------------------------------------------------------------------
`include "lru_page_replacement_top_assert.svh"

module lru_page_replacement_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [15:0] requested_page
   input  logic [lrupr_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [2:0] frame_index, [3] evicted_valid, [19:4] evicted_page,
   // [51:20] fault_total, [55:52] zero
   output logic [lrupr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // [0] page_fault
   output logic [lrupr_pkg::RSP_USER_W-1:0]  rsp_tuser,
   input  logic                              csr_wr_en,
   input  logic [lrupr_pkg::CFG_W-1:0]       csr_wr_data
);
   import lrupr_pkg::*;

   logic [COUNT_W-1:0]       frames_n_ff;
   logic [COUNT_W-1:0]       frames_n_in;
   logic [COUNT_W-1:0]       count_ff;
   logic [COUNT_W-1:0]       count_in;
   logic [FAULT_W-1:0]       fault_ff;
   logic [FAULT_W-1:0]       fault_in;

   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic                     rsp_fault_ff;
   logic                     rsp_fault_in;
   logic [FRAME_IDX_W-1:0]   rsp_frame_ff;
   logic [FRAME_IDX_W-1:0]   rsp_frame_in;
   logic                     rsp_evict_ff;
   logic                     rsp_evict_in;
   logic [EVICT_PAGE_W-1:0]  rsp_evict_page_ff;
   logic [EVICT_PAGE_W-1:0]  rsp_evict_page_in;
   logic [FAULT_W-1:0]       rsp_total_ff;
   logic [FAULT_W-1:0]       rsp_total_in;

   logic                     accept;
   logic [PAGE_BITS-1:0]     lookup_page;
   entry_type                cell_q    [FRAME_COUNT];
   entry_type                cell_prev [FRAME_COUNT];
   cell_ctrl_type            cell_ctrl [FRAME_COUNT];
   logic [FRAME_COUNT-1:0]   match_vec;
   logic [FRAME_COUNT-1:0]   valid_vec;
   logic [FRAME_COUNT:0]     match_tail;
   logic [FRAME_W-1:0]       hit_frame_or [FRAME_COUNT+1];
   logic                     hit;
   logic                     have_free;
   logic [FRAME_W-1:0]       victim_idx;
   entry_type                victim;
   entry_type                new_entry;

   assign req_tready  = !rsp_valid_ff || rsp_tready;
   assign accept      = req_tvalid && req_tready;
   assign lookup_page = PAGE_BITS'(req_tdata);

   // Suffix OR of the match vector marks every cell at or ahead of a hit.
   assign match_tail[FRAME_COUNT]   = 1'b0;
   assign hit_frame_or[FRAME_COUNT] = '0;

   for (genvar i = 0; i < FRAME_COUNT; i++) begin : g_chain
      if (i == 0) begin : g_head
         assign cell_prev[i] = new_entry;
      end else begin : g_link
         assign cell_prev[i] = cell_q[i-1];
      end

      assign match_tail[i]   = match_tail[i+1] | match_vec[i];
      assign hit_frame_or[i] = hit_frame_or[i+1] | (match_vec[i] ? cell_q[i].frame : '0);
      assign valid_vec[i]    = cell_q[i].valid;

      assign cell_ctrl[i].flush = csr_wr_en;
      assign cell_ctrl[i].load  = accept && (COUNT_W'(i) < frames_n_ff) &&
                                  (!hit || match_tail[i]);

      lrupr_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (cell_ctrl[i]),
         .prev_entry  (cell_prev[i]),
         .lookup_page (lookup_page),
         .entry       (cell_q[i]),
         .match       (match_vec[i])
      );
   end

   assign hit        = match_tail[0];
   assign have_free  = count_ff < frames_n_ff;
   assign victim_idx = FRAME_W'(frames_n_ff - 1'b1);
   assign victim     = cell_q[victim_idx];

   always_comb begin
      new_entry.valid = 1'b1;
      new_entry.page  = lookup_page;
      if (hit) begin
         new_entry.frame = hit_frame_or[0];
      end else if (have_free) begin
         new_entry.frame = FRAME_W'(count_ff);
      end else begin
         new_entry.frame = victim.frame;
      end
   end

   always_comb begin
      frames_n_in = frames_n_ff;
      count_in    = count_ff;
      fault_in    = fault_ff;
      if (csr_wr_en) begin
         frames_n_in = clamp_frames(csr_wr_data);
         count_in    = '0;
      end else if (accept && !hit) begin
         if (have_free) begin
            count_in = count_ff + 1'b1;
         end
         if (fault_ff != '1) begin
            fault_in = fault_ff + 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in      = rsp_valid_ff;
      rsp_fault_in      = rsp_fault_ff;
      rsp_frame_in      = rsp_frame_ff;
      rsp_evict_in      = rsp_evict_ff;
      rsp_evict_page_in = rsp_evict_page_ff;
      rsp_total_in      = rsp_total_ff;
      if (accept) begin
         rsp_valid_in      = 1'b1;
         rsp_fault_in      = !hit;
         rsp_frame_in      = FRAME_IDX_W'(new_entry.frame);
         rsp_evict_in      = !hit && !have_free;
         rsp_evict_page_in = (!hit && !have_free) ? EVICT_PAGE_W'(victim.page) : '0;
         rsp_total_in      = (!hit && (fault_ff != '1)) ? fault_ff + 1'b1 : fault_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_n_ff  <= clamp_frames(CFG_W'(CFG_RESET));
         count_ff     <= '0;
         fault_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         frames_n_ff  <= frames_n_in;
         count_ff     <= count_in;
         fault_ff     <= fault_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_fault_ff      <= rsp_fault_in;
      rsp_frame_ff      <= rsp_frame_in;
      rsp_evict_ff      <= rsp_evict_in;
      rsp_evict_page_ff <= rsp_evict_page_in;
      rsp_total_ff      <= rsp_total_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = RSP_USER_W'(rsp_fault_ff);
   assign rsp_tdata  = RSP_DATA_W'({rsp_total_ff, rsp_evict_page_ff, rsp_evict_ff,
                                    rsp_frame_ff});

   `LRUPR_ASSERT_ALWAYS(a_count_in_range, count_ff <= frames_n_ff,
      "fill count beyond frames")
   `LRUPR_ASSERT_ALWAYS(a_valid_matches_count, $countones(valid_vec) == 32'(count_ff),
      "valid cells differ from fill count")
   `LRUPR_ASSERT_ALWAYS(a_single_match, $onehot0(match_vec), "page resident in two cells")
   `LRUPR_ASSERT_NEXT(a_fill_step, accept && !hit && have_free && !csr_wr_en,
      count_ff == $past(count_ff) + 1'b1, "fill count did not advance")

endmodule

// File: dv/lru_page_replacement_top_tb.sv
// ----------------------------------------------------------------------------
// LRU page replacement table testbench
// Streams page references into the table and checks every result word
// against an in-bench model of the recency ranks, frame fill and eviction
// choice. A short table of directed references comes first. It is followed by
// random working-set traffic under a dozen frame count settings, with random
// gaps on both streams.
// ----------------------------------------------------------------------------
module lru_page_replacement_top_tb;
   import lrupr_pkg::*;

   localparam int MAX_WAIT        = 14;
   localparam int WATCHDOG_LIMIT  = 500;
   localparam int END_DRAIN       = 4;
   localparam int PHASE_ITEMS     = 138;
   localparam int PHASE_COUNT     = 12;
   localparam int PAUSE_PHASE     = 3;
   localparam int PAUSE_AT        = 69;
   localparam int POOL_MAX        = 12;
   localparam int DIRECTED_STEPS  = 29;

   typedef enum logic [0:0] {
      STEP_REFERENCE,
      STEP_SET_FRAMES
   } step_kind_type;

   typedef struct packed {
      logic                    page_fault;
      logic [FRAME_IDX_W-1:0]  frame_index;
      logic                    evicted_valid;
      logic [EVICT_PAGE_W-1:0] evicted_page;
      logic [FAULT_W-1:0]      fault_total;
   } page_result_type;

   typedef struct packed {
      step_kind_type         kind;
      logic [REQ_PAGE_W-1:0] value;
      logic                  typed;
      page_result_type       want;
   } directed_step_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic [RSP_USER_W-1:0]   rsp_tuser;
   logic                    csr_wr_en = 1'b0;
   logic [CFG_W-1:0]        csr_wr_data = '0;

   // Shadow of the replacement table.
   logic [PAGE_BITS-1:0]    frame_page [FRAME_COUNT];
   logic                    frame_valid [FRAME_COUNT];
   logic [FRAME_IDX_W-1:0]  recency_rank [FRAME_COUNT];
   logic [FAULT_W-1:0]      fault_count = '0;
   logic [CFG_W-1:0]        frames_setting = CFG_W'(CFG_RESET);

   page_result_type         expected_lookups [$];
   int                      lookups_in_flight = 0;
   int                      error_count = 0;
   int                      gap_ahead = 0;
   int                      pages_sent = 0;
   bit                      req_burst = 1'b0;
   int                      rsp_stall_left = 0;
   int                      rsp_seen = 0;
   bit                      rsp_burst = 1'b0;
   int                      idle_cycles = 0;

   logic [CFG_W-1:0]        phase_frames [PHASE_COUNT] =
      '{4'd8, 4'd1, 4'd0, 4'd4, 4'd15, 4'd9, 4'd2, 4'd7, 4'd3, 4'd5, 4'd6, 4'd8};

   // Typed rows: values that follow directly from an empty table.
   directed_step_type directed_steps [DIRECTED_STEPS] = '{
      '{STEP_REFERENCE,  16'h0000, 1'b1, '{1'b1, 3'd0, 1'b0, 16'h0000, 32'd1}},
      '{STEP_REFERENCE,  16'hFFFF, 1'b1, '{1'b1, 3'd1, 1'b0, 16'h0000, 32'd2}},
      '{STEP_REFERENCE,  16'h0000, 1'b1, '{1'b0, 3'd0, 1'b0, 16'h0000, 32'd2}},
      '{STEP_REFERENCE,  16'hFFFF, 1'b1, '{1'b0, 3'd1, 1'b0, 16'h0000, 32'd2}},
      '{STEP_SET_FRAMES, 16'h0001, 1'b0, '0},
      '{STEP_REFERENCE,  16'h1234, 1'b1, '{1'b1, 3'd0, 1'b0, 16'h0000, 32'd3}},
      '{STEP_REFERENCE,  16'h1234, 1'b1, '{1'b0, 3'd0, 1'b0, 16'h0000, 32'd3}},
      '{STEP_REFERENCE,  16'hABCD, 1'b1, '{1'b1, 3'd0, 1'b1, 16'h1234, 32'd4}},
      '{STEP_SET_FRAMES, 16'h0000, 1'b0, '0},
      '{STEP_REFERENCE,  16'h5555, 1'b1, '{1'b1, 3'd0, 1'b0, 16'h0000, 32'd5}},
      '{STEP_REFERENCE,  16'hAAAA, 1'b1, '{1'b1, 3'd0, 1'b1, 16'h5555, 32'd6}},
      '{STEP_SET_FRAMES, 16'h000F, 1'b0, '0},
      '{STEP_REFERENCE,  16'h0001, 1'b0, '0},
      '{STEP_REFERENCE,  16'h0002, 1'b0, '0},
      '{STEP_REFERENCE,  16'h0004, 1'b0, '0},
      '{STEP_REFERENCE,  16'h0008, 1'b0, '0},
      '{STEP_REFERENCE,  16'h0010, 1'b0, '0},
      '{STEP_REFERENCE,  16'h0020, 1'b0, '0},
      '{STEP_REFERENCE,  16'h0040, 1'b0, '0},
      '{STEP_REFERENCE,  16'h0080, 1'b0, '0},
      '{STEP_REFERENCE,  16'h0001, 1'b0, '0},
      '{STEP_REFERENCE,  16'h8000, 1'b0, '0},
      '{STEP_SET_FRAMES, 16'h0009, 1'b0, '0},
      '{STEP_REFERENCE,  16'h0100, 1'b0, '0},
      '{STEP_SET_FRAMES, 16'h0002, 1'b0, '0},
      '{STEP_REFERENCE,  16'h7FFF, 1'b0, '0},
      '{STEP_REFERENCE,  16'h8000, 1'b0, '0},
      '{STEP_REFERENCE,  16'h7FFF, 1'b0, '0},
      '{STEP_REFERENCE,  16'h0F0F, 1'b0, '0}
   };

   lru_page_replacement_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int active_frames(input logic [CFG_W-1:0] setting);
      int n;
      n = int'(setting);
      if (n < 1) n = 1;
      if (n > FRAME_COUNT) n = FRAME_COUNT;
      return n;
   endfunction

   function automatic void clear_frames();
      for (int i = 0; i < FRAME_COUNT; i++) begin
         frame_page[i]   = '0;
         frame_valid[i]  = 1'b0;
         recency_rank[i] = '0;
      end
   endfunction

   // Looks the page up, updates the shadow table and returns the result word.
   function automatic page_result_type predict_lookup(input logic [PAGE_BITS-1:0] page);
      page_result_type r;
      int              n;
      int              slot;
      int              age_limit;
      bit              hit;
      bit              found_free;
      n    = active_frames(frames_setting);
      hit  = 1'b0;
      slot = 0;
      r    = '0;
      for (int i = 0; i < n; i++) begin
         if (!hit && frame_valid[i] && frame_page[i] == page) begin
            hit  = 1'b1;
            slot = i;
         end
      end
      if (hit) begin
         age_limit = int'(recency_rank[slot]);
      end else begin
         found_free = 1'b0;
         for (int i = 0; i < n; i++) begin
            if (!found_free && !frame_valid[i]) begin
               found_free = 1'b1;
               slot       = i;
            end
         end
         // With no free frame, the oldest rank loses and ties go to the lowest frame.
         if (!found_free) begin
            slot = 0;
            for (int i = 1; i < n; i++) begin
               if (recency_rank[i] > recency_rank[slot]) slot = i;
            end
            r.evicted_valid   = 1'b1;
            r.evicted_page    = frame_page[slot];
            frame_valid[slot] = 1'b0;
         end
         age_limit = FRAME_COUNT;
      end
      for (int i = 0; i < n; i++) begin
         if (frame_valid[i] && int'(recency_rank[i]) < age_limit &&
             int'(recency_rank[i]) < FRAME_COUNT - 1) begin
            recency_rank[i] = recency_rank[i] + 1'b1;
         end
      end
      frame_page[slot]   = page;
      frame_valid[slot]  = 1'b1;
      recency_rank[slot] = '0;
      if (!hit && fault_count != '1) fault_count = fault_count + 1'b1;
      r.page_fault  = !hit;
      r.frame_index = FRAME_IDX_W'(slot);
      r.fault_total = fault_count;
      return r;
   endfunction

   // Sends one reference. The valid stays high only when the next word follows
   // at once, so a word is never offered twice.
   task automatic send_page(input logic [PAGE_BITS-1:0] page, input logic typed,
                            input page_result_type typed_want, input bit more);
      page_result_type want;
      repeat (gap_ahead) @(posedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= page;
      do @(posedge clock); while (!req_tready);
      want = predict_lookup(page);
      if (typed) want = typed_want;
      expected_lookups.push_back(want);
      lookups_in_flight++;
      pages_sent++;
      if (pages_sent % 32 == 0) req_burst = ($urandom_range(0, 3) == 0);
      gap_ahead = req_burst ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap_ahead != 0 || !more) req_tvalid <= 1'b0;
   endtask

   task automatic set_frames(input logic [CFG_W-1:0] value);
      wait (lookups_in_flight == 0);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      frames_setting = value;
      clear_frames();
   endtask

   initial begin
      logic [PAGE_BITS-1:0] page_pool [POOL_MAX];
      logic [PAGE_BITS-1:0] page;
      int                   pool_size;
      bit                   pause;
      bit                   more;
      clear_frames();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int s = 0; s < DIRECTED_STEPS; s++) begin
         more = (s < DIRECTED_STEPS - 1) ?
                (directed_steps[s + 1].kind == STEP_REFERENCE) : 1'b0;
         if (directed_steps[s].kind == STEP_SET_FRAMES) begin
            set_frames(directed_steps[s].value[CFG_W-1:0]);
         end else begin
            send_page(directed_steps[s].value, directed_steps[s].typed,
                      directed_steps[s].want, more);
         end
      end

      // Most references come from a working set the size of the table or up to
      // three pages larger, so hits, fills and evictions all happen often.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         set_frames(phase_frames[p]);
         pool_size = active_frames(phase_frames[p]) + $urandom_range(0, 3);
         for (int i = 0; i < POOL_MAX; i++) page_pool[i] = PAGE_BITS'($urandom);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if ($urandom_range(0, 49) == 0) begin
               page_pool[$urandom_range(0, pool_size - 1)] = PAGE_BITS'($urandom);
            end
            if ($urandom_range(0, 9) < 8) begin
               page = page_pool[$urandom_range(0, pool_size - 1)];
            end else begin
               page = PAGE_BITS'($urandom_range(0, 16'hFFFF));
            end
            pause = (p == PAUSE_PHASE && k == PAUSE_AT);
            more  = (k != PHASE_ITEMS - 1) && !pause;
            send_page(page, 1'b0, '0, more);
            if (pause) wait (lookups_in_flight == 0);
         end
      end

      wait (lookups_in_flight == 0);
      repeat (END_DRAIN) @(posedge clock);
      if (error_count == 0) begin
         $display("lru_page_replacement_top_tb: done, clean");
      end else begin
         $display("lru_page_replacement_top_tb: done, errors");
      end
      $finish;
   end

   // Result side: random stalls, field checks and the watchdog.
   always @(posedge clock) begin
      page_result_type got;
      page_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.page_fault    = rsp_tuser[0];
            got.frame_index   = rsp_tdata[2:0];
            got.evicted_valid = rsp_tdata[3];
            got.evicted_page  = rsp_tdata[19:4];
            got.fault_total   = rsp_tdata[51:20];
            if (expected_lookups.size() == 0) begin
               $error("result word with no reference pending");
               error_count++;
            end else begin
               want = expected_lookups.pop_front();
               lookups_in_flight--;
               if (got.page_fault !== want.page_fault) begin
                  $error("page_fault: expected %0d, actual %0d",
                         want.page_fault, got.page_fault);
                  error_count++;
               end
               if (got.frame_index !== want.frame_index) begin
                  $error("frame_index: expected %0d, actual %0d",
                         want.frame_index, got.frame_index);
                  error_count++;
               end
               if (got.evicted_valid !== want.evicted_valid) begin
                  $error("evicted_valid: expected %0d, actual %0d",
                         want.evicted_valid, got.evicted_valid);
                  error_count++;
               end
               if (got.evicted_page !== want.evicted_page) begin
                  $error("evicted_page: expected %h, actual %h",
                         want.evicted_page, got.evicted_page);
                  error_count++;
               end
               if (got.fault_total !== want.fault_total) begin
                  $error("fault_total: expected %0d, actual %0d",
                         want.fault_total, got.fault_total);
                  error_count++;
               end
               if (rsp_tdata[RSP_DATA_W-1:52] !== '0) begin
                  $error("padding: expected 0, actual %h", rsp_tdata[RSP_DATA_W-1:52]);
                  error_count++;
               end
            end
            rsp_seen++;
            if (rsp_seen % 32 == 0) rsp_burst = ($urandom_range(0, 3) == 0);
            rsp_stall_left = rsp_burst ? 0 : $urandom_range(0, MAX_WAIT);
         end else if (rsp_tvalid && rsp_stall_left > 0) begin
            rsp_stall_left--;
         end
         rsp_tready <= (rsp_stall_left == 0);
      end

      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("lru_page_replacement_top_tb: done, errors");
         $finish;
      end
   end

endmodule
